[design/piecewise_poly_trajectory_eval_assert.svh]
// Assertion macros used by the checker file of the trajectory evaluator.
`ifndef PIECEWISE_POLY_TRAJECTORY_EVAL_ASSERT_SVH
`define PIECEWISE_POLY_TRAJECTORY_EVAL_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define PPTE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PPTE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ppte_pkg.sv]
// Types, constants and helper functions of the trajectory evaluator.
package ppte_pkg;

   localparam int COEFF_W   = 48;
   localparam int TIME_W    = 32;
   localparam int HALF_T_W  = 16;
   localparam int PROD_W    = 64;
   localparam int SAT_IN_W  = 65;
   localparam int FACTOR_W  = 8;
   localparam int NUM_DERIV = 3;
   localparam int OUT_AXES  = 3;
   localparam int ORDER_W   = 3;
   localparam int AXIS_W    = 2;
   localparam int SEG_W     = 4;
   localparam int IDX_W     = 3;
   // Wide enough for any coefficient index the parameters allow.
   localparam int KIDX_W    = 4;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   typedef logic signed [COEFF_W-1:0] coeff_type;

   localparam coeff_type COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
   localparam coeff_type COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WGT,
      ST_MLO,
      ST_MHI,
      ST_FIN,
      ST_AXIS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              clear;
      logic              wgt;
      logic              mlo;
      logic              mhi;
      logic              fin;
      logic              first;
      logic [1:0]        deriv;
      logic [KIDX_W-1:0] kidx;
   } horner_ctrl_type;

   // Derivative weight of the coefficient of t^k: 1, k or k(k-1).
   function automatic logic [FACTOR_W-1:0] weight_factor(input logic [KIDX_W-1:0] k,
                                                         input logic [1:0] d);
      logic [FACTOR_W-1:0] kk;
      logic [FACTOR_W-1:0] km1;
      kk  = FACTOR_W'(k);
      km1 = FACTOR_W'(k) - FACTOR_W'(1);
      case (d)
         2'd0: begin
            return FACTOR_W'(1);
         end
         2'd1: begin
            return kk;
         end
         2'd2: begin
            return FACTOR_W'(kk * km1);
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   // Saturates a wide signed value to the coefficient range.
   function automatic coeff_type sat_coeff(input logic signed [SAT_IN_W-1:0] x);
      if (x[SAT_IN_W-1] && !(&x[SAT_IN_W-2:COEFF_W-1])) begin
         return COEFF_MIN;
      end else if (!x[SAT_IN_W-1] && (|x[SAT_IN_W-2:COEFF_W-1])) begin
         return COEFF_MAX;
      end else begin
         return x[COEFF_W-1:0];
      end
   endfunction

endpackage

[design/ppte_if.sv]
// Request and response channel interfaces of the trajectory evaluator.
interface ppte_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [1:0]                  axis;
   logic [3:0]                  segment;
   logic [2:0]                  coeff_index;
   logic signed [47:0]          coeff_value;
   logic [31:0]                 sample_time;

   modport source (output valid, func, axis, segment, coeff_index, coeff_value,
                   sample_time, input ready);
   modport sink (input valid, func, axis, segment, coeff_index, coeff_value,
                 sample_time, output ready);
endinterface

interface ppte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] pos_x;
   logic signed [47:0] pos_y;
   logic signed [47:0] pos_z;
   logic signed [47:0] vel_x;
   logic signed [47:0] vel_y;
   logic signed [47:0] vel_z;
   logic signed [47:0] acc_x;
   logic signed [47:0] acc_y;
   logic signed [47:0] acc_z;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   acc_x, acc_y, acc_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 acc_x, acc_y, acc_z, output ready);
endinterface

[design/piecewise_poly_trajectory_eval.sv]
// Top level of the piecewise polynomial trajectory evaluator.
// The req_chan channel carries one transaction per item: func 0 loads one coefficient
// into the store, func 1 evaluates a segment at sample_time. Writes give no response.
// An evaluation gives one rsp_chan transaction with position, velocity and acceleration
// for the three axes. The derivative order is set through csr_wr_en and csr_wr_data;
// the user must write it only while the block is idle, as the block does not enforce it.
// An evaluation is worked coefficient by coefficient from the store, highest power
// first: each coefficient takes one memory read and then, for each derivative that it
// feeds, one update through the one shared multiply path (weight, low and high time
// products, round and add); for the first coefficient the time products are skipped.
// Only one evaluation is in flight; req_chan.ready is low meanwhile.
// A finished result waits in an output register, so new transactions are accepted
// while the receiver stalls; a further result waits until that register is free.
// Synchronous reset clears the control state and sets the order to four; the store
// is not cleared and must be written before it is read.
module piecewise_poly_trajectory_eval
   import ppte_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_COEFFS   = 8,
   parameter int AXES         = 3
) (
   input  logic               clock,
   input  logic               reset,
   ppte_req_if.sink           req_chan,
   ppte_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [ORDER_W-1:0] csr_wr_data
);

   localparam int DEPTH  = AXES * MAX_SEGMENTS * MAX_COEFFS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int KW     = $clog2(MAX_COEFFS + 1);

   state_type state_ff, state_in;
   logic [ORDER_W-1:0]  order_ff;
   logic [AXIS_W-1:0]   a_ff;
   logic [KW-1:0]       k_ff;
   logic [KW-1:0]       n_ff;
   logic [1:0]          d_ff;
   logic [SEG_W-1:0]    seg_ff;
   logic [TIME_W-1:0]   t_ff;
   logic                rsp_valid_ff;
   logic [NUM_DERIV-1:0][OUT_AXES-1:0][COEFF_W-1:0] res_ff;
   logic [NUM_DERIV-1:0][OUT_AXES-1:0][COEFF_W-1:0] rsp_ff;

   logic                req_fire;
   logic                eval_fire;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_en;
   logic [ORDER_W:0]    two_n;
   logic [KW-1:0]       n_in;
   logic                first;
   logic                more_d;
   logic                last_axis;
   logic                leave_done;
   coeff_type           rd_data;
   horner_ctrl_type     ctrl;
   logic [NUM_DERIV-1:0][COEFF_W-1:0] acc;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign eval_fire = req_fire && (req_chan.func == FUNC_EVAL);
   assign two_n     = {order_ff, 1'b0};
   assign n_in      = (32'(two_n) > MAX_COEFFS) ? KW'(MAX_COEFFS) : KW'(two_n);
   assign first     = (k_ff == n_ff - KW'(1));
   assign more_d    = (32'(d_ff) + 1 < NUM_DERIV) && (32'(d_ff) + 1 <= 32'(k_ff));
   assign last_axis = (32'(a_ff) + 1 >= AXES);
   assign leave_done = !rsp_valid_ff || rsp_chan.ready;

   // Writes land at the accepting edge, before any later evaluation reads the store.
   assign wr_en   = req_fire && (req_chan.func == FUNC_WRITE)
                    && (32'(req_chan.axis) < AXES)
                    && (32'(req_chan.segment) < MAX_SEGMENTS)
                    && (32'(req_chan.coeff_index) < MAX_COEFFS);
   assign wr_addr = ADDR_W'((32'(req_chan.axis) * MAX_SEGMENTS + 32'(req_chan.segment))
                            * MAX_COEFFS + 32'(req_chan.coeff_index));
   assign rd_addr = ADDR_W'((32'(a_ff) * MAX_SEGMENTS + 32'(seg_ff)) * MAX_COEFFS
                            + 32'(k_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (eval_fire) begin
               if ((n_in == '0) || (32'(req_chan.segment) >= MAX_SEGMENTS)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_WGT;
         end
         ST_WGT: begin
            state_in = first ? ST_FIN : ST_MLO;
         end
         ST_MLO: begin
            state_in = ST_MHI;
         end
         ST_MHI: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (more_d) begin
               state_in = ST_WGT;
            end else if (k_ff != '0) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            state_in = last_axis ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (leave_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      ctrl           = '0;
      ctrl.deriv     = d_ff;
      ctrl.kidx      = KIDX_W'(k_ff);
      ctrl.first     = first;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            ctrl.clear     = eval_fire;
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_WGT: begin
            ctrl.wgt = 1'b1;
         end
         ST_MLO: begin
            ctrl.mlo = 1'b1;
         end
         ST_MHI: begin
            ctrl.mhi = 1'b1;
         end
         ST_FIN: begin
            ctrl.fin = 1'b1;
         end
         ST_AXIS: begin
            ctrl.clear = 1'b1;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= ORDER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         if ((state_ff == ST_DONE) && leave_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (eval_fire) begin
               seg_ff <= req_chan.segment;
               t_ff   <= req_chan.sample_time;
               n_ff   <= n_in;
               a_ff   <= '0;
               k_ff   <= n_in - KW'(1);
               d_ff   <= '0;
               res_ff <= '0;
            end
         end
         ST_FIN: begin
            if (more_d) begin
               d_ff <= d_ff + 2'd1;
            end else if (k_ff != '0) begin
               k_ff <= k_ff - KW'(1);
               d_ff <= '0;
            end
         end
         ST_AXIS: begin
            for (int d = 0; d < NUM_DERIV; d++) begin
               res_ff[d][a_ff] <= acc[d];
            end
            a_ff <= a_ff + AXIS_W'(1);
            k_ff <= n_ff - KW'(1);
            d_ff <= '0;
         end
         ST_DONE: begin
            if (leave_done) begin
               rsp_ff <= res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   ppte_coeff_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.coeff_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ppte_horner_unit u_horner (
      .clock       (clock),
      .ctrl        (ctrl),
      .coeff       (rd_data),
      .sample_time (t_ff),
      .acc         (acc)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pos_x = rsp_ff[0][0];
   assign rsp_chan.pos_y = rsp_ff[0][1];
   assign rsp_chan.pos_z = rsp_ff[0][2];
   assign rsp_chan.vel_x = rsp_ff[1][0];
   assign rsp_chan.vel_y = rsp_ff[1][1];
   assign rsp_chan.vel_z = rsp_ff[1][2];
   assign rsp_chan.acc_x = rsp_ff[2][0];
   assign rsp_chan.acc_y = rsp_ff[2][1];
   assign rsp_chan.acc_z = rsp_ff[2][2];

endmodule

[design/ppte_coeff_ram.sv]
// Coefficient store: one write port, one registered read port.
module ppte_coeff_ram
   import ppte_pkg::*;
#(
   parameter int DEPTH  = 384,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  coeff_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output coeff_type         rd_data
);

   coeff_type mem_ff [DEPTH];
   coeff_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ppte_horner_unit.sv]
// Shared Horner datapath: derivative weighting, split time multiply, saturating add.
module ppte_horner_unit
   import ppte_pkg::*;
(
   input  logic                                 clock,
   input  horner_ctrl_type                      ctrl,
   input  coeff_type                            coeff,
   input  logic [TIME_W-1:0]                    sample_time,
   output logic [NUM_DERIV-1:0][COEFF_W-1:0]    acc
);

   logic [NUM_DERIV-1:0][COEFF_W-1:0] acc_ff;
   coeff_type                         w_ff;
   logic [COEFF_W-1:0]                mag_ff;
   logic                              neg_ff;
   logic [PROD_W-1:0]                 plo_ff;
   logic [PROD_W-1:0]                 p_ff;

   logic signed [COEFF_W+FACTOR_W:0]  wprod;
   coeff_type                         w_in;
   logic [COEFF_W-1:0]                cur;
   logic [COEFF_W-1:0]                mag_in;
   coeff_type                         mprod;
   coeff_type                         fin_in;

   always_comb begin
      wprod  = coeff * $signed({{(COEFF_W+1){1'b0}}, weight_factor(ctrl.kidx, ctrl.deriv)});
      w_in   = sat_coeff(SAT_IN_W'(wprod));
      cur    = acc_ff[ctrl.deriv];
      mag_in = cur[COEFF_W-1] ? (~cur + COEFF_W'(1)) : cur;
      // The product is rounded on its magnitude, so the sign is put back afterwards.
      if (neg_ff) begin
         if (p_ff >= {{(PROD_W-COEFF_W){1'b0}}, COEFF_MIN}) begin
            mprod = COEFF_MIN;
         end else begin
            mprod = ~p_ff[COEFF_W-1:0] + COEFF_W'(1);
         end
      end else begin
         if (p_ff > PROD_W'(COEFF_MAX)) begin
            mprod = COEFF_MAX;
         end else begin
            mprod = p_ff[COEFF_W-1:0];
         end
      end
      if (ctrl.first) begin
         fin_in = w_ff;
      end else begin
         fin_in = sat_coeff(SAT_IN_W'(mprod) + SAT_IN_W'(w_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.fin) begin
         acc_ff[ctrl.deriv] <= fin_in;
      end
      if (ctrl.wgt) begin
         w_ff   <= w_in;
         mag_ff <= mag_in;
         neg_ff <= cur[COEFF_W-1];
      end
      if (ctrl.mlo) begin
         plo_ff <= PROD_W'(mag_ff) * PROD_W'(sample_time[HALF_T_W-1:0]);
      end
      if (ctrl.mhi) begin
         p_ff <= PROD_W'(mag_ff) * PROD_W'(sample_time[TIME_W-1:HALF_T_W])
               + ((plo_ff + PROD_W'(32768)) >> HALF_T_W);
      end
   end

   assign acc = acc_ff;

endmodule

[design/ppte_checker.sv]
// Port-level checker of the trajectory evaluator and its bind statement.
`include "piecewise_poly_trajectory_eval_assert.svh"

module ppte_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_func,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A stalled response stays offered.
   `PPTE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // Reset leaves no response pending.
   `PPTE_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "response valid after reset")

   // A coefficient write with nothing pending never produces a response.
   `PPTE_ASSERT(a_write_silent, clock, reset, req_valid && req_ready && !req_func && !rsp_valid |=> !rsp_valid, "write produced a response")

   // An accepted evaluation holds off the next transaction.
   `PPTE_ASSERT(a_eval_busy, clock, reset, req_valid && req_ready && req_func |=> !req_ready, "ready high during evaluation")

endmodule

bind piecewise_poly_trajectory_eval ppte_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_func  (req_chan.func),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

[verif/tb_top.sv]
// Self-checking testbench of the piecewise polynomial trajectory evaluator.
module tb_top;
   import ppte_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSEG        = 16;
   localparam int NCOEF       = 8;
   localparam int NAX         = 3;
   localparam int NFIELD      = 9;
   localparam int SETTLE      = 400;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int RAND_ITEMS  = 1100;

   typedef logic [NFIELD-1:0][COEFF_W-1:0] traj_type;

   typedef struct {
      logic      func;
      logic [1:0] axis;
      logic [3:0] segment;
      logic [2:0] coeff_index;
      coeff_type  coeff_value;
      logic [31:0] sample_time;
      bit         literal;
      traj_type   lit_traj;
   } stim_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ORDER_W-1:0] csr_wr_data;

   ppte_req_if req_chan ();
   ppte_rsp_if rsp_chan ();

   piecewise_poly_trajectory_eval dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   coeff_type      coeff_mem [NAX][NSEG][NCOEF];
   logic [2:0]     order_q;
   traj_type       traj_q [$];
   bit             quiet;
   int unsigned    err_count;
   int unsigned    sent_count;
   int unsigned    checked_count;
   int unsigned    phase_count;
   int unsigned    cycles = 0;
   stim_type       dir_tab [12];

   initial begin
      clock = 1'b0;
      forever begin
         #10 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic longint sat48(input longint x);
      if (x > longint'(COEFF_MAX)) begin
         return longint'(COEFF_MAX);
      end else if (x < longint'(COEFF_MIN)) begin
         return longint'(COEFF_MIN);
      end
      return x;
   endfunction

   // Q16.32 times unsigned Q16.16, rounded half away from zero.
   function automatic longint scale_by_time(input longint a, input logic [31:0] t);
      bit neg;
      logic [63:0] mag;
      logic [63:0] p;
      neg = a < 0;
      mag = neg ? 64'(-a) : 64'(a);
      p = mag * 64'(t[31:16]) + ((mag * 64'(t[15:0]) + 64'h8000) >> 16);
      if (neg) begin
         if (p >= 64'h8000_0000_0000) begin
            return longint'(COEFF_MIN);
         end
         return -longint'(p);
      end
      if (p > 64'(COEFF_MAX)) begin
         return longint'(COEFF_MAX);
      end
      return longint'(p);
   endfunction

   function automatic longint deriv_weight(input coeff_type c, input int i, input int d);
      longint f;
      f = 1;
      for (int k = 0; k < d; k++) begin
         f = f * (i - k);
      end
      return sat48(longint'(c) * f);
   endfunction

   function automatic longint horner_eval(input int ax, input int seg, input int n,
                                          input int d, input logic [31:0] t);
      longint acc;
      if (n <= d) begin
         return 0;
      end
      acc = deriv_weight(coeff_mem[ax][seg][n-1], n - 1, d);
      for (int i = n - 1; i > d; i--) begin
         acc = sat48(scale_by_time(acc, t) + deriv_weight(coeff_mem[ax][seg][i-1], i - 1, d));
      end
      return acc;
   endfunction

   function automatic traj_type predict_traj(input logic [3:0] seg, input logic [31:0] t);
      traj_type r;
      int n;
      longint v;
      n = 2 * int'(order_q);
      if (n > NCOEF) begin
         n = NCOEF;
      end
      for (int a = 0; a < NAX; a++) begin
         for (int d = 0; d < 3; d++) begin
            v = horner_eval(a, seg, n, d, t);
            r[d*3+a] = v[COEFF_W-1:0];
         end
      end
      return r;
   endfunction

   // Drives one transaction and updates the predicted state when it is accepted.
   task automatic send_item(input stim_type s);
      if (!quiet) begin
         while ($urandom_range(99) < 15) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.func        = s.func;
      req_chan.axis        = s.axis;
      req_chan.segment     = s.segment;
      req_chan.coeff_index = s.coeff_index;
      req_chan.coeff_value = s.coeff_value;
      req_chan.sample_time = s.sample_time;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      sent_count++;
      if (s.func == FUNC_WRITE) begin
         if (s.axis < NAX) begin
            coeff_mem[s.axis][s.segment][s.coeff_index] = s.coeff_value;
         end
      end else if (s.literal) begin
         traj_q.insert(traj_q.size(), s.lit_traj);
      end else begin
         traj_q.insert(traj_q.size(), predict_traj(s.segment, s.sample_time));
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (traj_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_order(input logic [2:0] ord);
      drain_results();
      csr_wr_en   = 1'b1;
      csr_wr_data = ord;
      @(negedge clock);
      csr_wr_en = 1'b0;
      order_q   = ord;
      phase_count++;
   endtask

   function automatic stim_type random_item();
      stim_type s;
      int pick;
      s.literal     = 1'b0;
      s.lit_traj    = '0;
      s.func        = ($urandom_range(99) < 55) ? FUNC_EVAL : FUNC_WRITE;
      s.axis        = ($urandom_range(99) < 5) ? 2'd3 : 2'($urandom_range(2));
      s.segment     = 4'($urandom_range(15));
      s.coeff_index = 3'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 60) begin
         s.coeff_value = coeff_type'(signed'(37'({$urandom, $urandom})));
      end else if (pick < 85) begin
         s.coeff_value = 48'({$urandom, $urandom});
      end else begin
         case ($urandom_range(4))
            0: s.coeff_value = COEFF_MAX;
            1: s.coeff_value = COEFF_MIN;
            2: s.coeff_value = '0;
            3: s.coeff_value = '1;
            default: s.coeff_value = 48'd1;
         endcase
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
         s.sample_time = 32'($urandom_range(32'h3ffff));
      end else if (pick < 90) begin
         s.sample_time = $urandom;
      end else begin
         case ($urandom_range(2))
            0: s.sample_time = '0;
            1: s.sample_time = '1;
            default: s.sample_time = 32'h1_0000;
         endcase
      end
      return s;
   endfunction

   // Response side: random back-pressure, field by field comparison.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = quiet ? 1'b1 : ($urandom_range(99) >= 15);
      end
   end

   always @(posedge clock) begin
      traj_type got;
      traj_type want;
      string names [NFIELD];
      names = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                "acc_x", "acc_y", "acc_z"};
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.acc_z, rsp_chan.acc_y, rsp_chan.acc_x,
                rsp_chan.vel_z, rsp_chan.vel_y, rsp_chan.vel_x,
                rsp_chan.pos_z, rsp_chan.pos_y, rsp_chan.pos_x};
         if (traj_q.size() == 0) begin
            $error("response transaction with no evaluation outstanding");
            err_count++;
         end else begin
            want = traj_q.pop_front();
            checked_count++;
            for (int f = 0; f < NFIELD; f++) begin
               if (got[f] !== want[f]) begin
                  $error("%s expected %h actual %h", names[f], want[f], got[f]);
                  err_count++;
               end
            end
         end
      end
   end

   initial begin
      stim_type s;
      int unsigned wait_cycles;
      logic [2:0] orders [6];
      orders = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd4};
      err_count = 0;
      sent_count = 0;
      checked_count = 0;
      phase_count = 0;
      quiet = 1'b0;
      order_q = ORDER_RESET;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_WRITE;
      req_chan.axis = '0;
      req_chan.segment = '0;
      req_chan.coeff_index = '0;
      req_chan.coeff_value = '0;
      req_chan.sample_time = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Fill the whole store with zeros so that no evaluation reads an unwritten entry.
      s = '{default: '0};
      s.func = FUNC_WRITE;
      for (int a = 0; a < NAX; a++) begin
         for (int g = 0; g < NSEG; g++) begin
            for (int k = 0; k < NCOEF; k++) begin
               s.axis = 2'(a);
               s.segment = 4'(g);
               s.coeff_index = 3'(k);
               send_item(s);
            end
         end
      end

      // Directed transactions at the reset order of four.
      dir_tab[0] = '{FUNC_EVAL, 2'd0, 4'd0, 3'd0, '0, 32'hffff_ffff, 1'b1, '0};
      dir_tab[1] = '{FUNC_WRITE, 2'd0, 4'd1, 3'd0, COEFF_MAX, '0, 1'b0, '0};
      dir_tab[2] = '{FUNC_WRITE, 2'd0, 4'd1, 3'd1, COEFF_MIN, '0, 1'b0, '0};
      dir_tab[3] = '{FUNC_WRITE, 2'd1, 4'd1, 3'd2, 48'd1, '0, 1'b0, '0};
      // At time zero the outputs are c0, c1 and twice c2.
      dir_tab[4] = '{FUNC_EVAL, 2'd3, 4'd1, 3'd7, '1, 32'h0, 1'b1, '0};
      dir_tab[4].lit_traj[0] = COEFF_MAX;
      dir_tab[4].lit_traj[3] = COEFF_MIN;
      dir_tab[4].lit_traj[7] = 48'd2;
      dir_tab[5] = '{FUNC_WRITE, 2'd2, 4'd2, 3'd7, COEFF_MAX, '0, 1'b0, '0};
      dir_tab[6] = '{FUNC_EVAL, 2'd0, 4'd2, 3'd0, '0, 32'hffff_ffff, 1'b0, '0};
      dir_tab[7] = '{FUNC_WRITE, 2'd2, 4'd2, 3'd7, COEFF_MIN, '0, 1'b0, '0};
      dir_tab[8] = '{FUNC_EVAL, 2'd0, 4'd2, 3'd0, '0, 32'hffff_ffff, 1'b0, '0};
      // A write to the fourth axis is dropped, so segment three stays zero.
      dir_tab[9] = '{FUNC_WRITE, 2'd3, 4'd3, 3'd0, 48'h1234_5678_9abc, '0, 1'b0, '0};
      dir_tab[10] = '{FUNC_EVAL, 2'd0, 4'd3, 3'd0, '0, 32'h1_0000, 1'b1, '0};
      dir_tab[11] = '{FUNC_EVAL, 2'd0, 4'd15, 3'd0, '0, 32'h1_8000, 1'b0, '0};
      for (int r = 0; r < 12; r++) begin
         send_item(dir_tab[r]);
      end

      for (int p = 0; p < 6; p++) begin
         write_order(orders[p]);
         for (int i = 0; i < RAND_ITEMS / 6; i++) begin
            quiet = (p == 2) && (i >= 50) && (i < 200);
            // Hold off mid-phase until every outstanding result has come back.
            if (p == 1 && i == 100) begin
               drain_results();
            end
            send_item(random_item());
         end
         quiet = 1'b0;
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      wait_cycles = 0;
      while (traj_q.size() != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (SETTLE) @(negedge clock);
      $display("%0d request transactions sent, %0d responses checked", sent_count,
               checked_count);
      $display("%0d derivative orders exercised, including zero and beyond the cap",
               phase_count + 1);
      if (err_count == 0 && traj_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (traj_q.size() != 0) begin
            $error("%0d evaluations never answered", traj_q.size());
         end
         $display("simulation failed");
      end
      $finish;
   end

endmodule
